@@ hdl/s2s_pkg.sv @@
`timescale 1ns / 1ps
package s2s_pkg;
   localparam int COORD_WIDTH = 24;
   localparam int DIST_WIDTH  = 25;
   localparam int CFG_WIDTH   = 16;
   localparam int T_BITS      = 16;
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
   localparam int DOT_WIDTH   = PROD_WIDTH + 1;
   localparam int TQ_WIDTH    = T_BITS + 1;
   localparam int TMUL_WIDTH  = DIFF_WIDTH + TQ_WIDTH + 1;
   localparam int ERR_WIDTH   = DIFF_WIDTH + 1;
   localparam int SQ_WIDTH    = 2 * ERR_WIDTH;
   localparam int LANE_LAT    = 4 + T_BITS + 4 + ERR_WIDTH;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic REG_TOUCH_TOL = 1'b0;
   localparam logic REG_DEGEN_LEN = 1'b1;
   localparam logic [CFG_WIDTH-1:0] TOUCH_TOL_RESET = CFG_WIDTH'(26);
   localparam logic [CFG_WIDTH-1:0] DEGEN_LEN_RESET = CFG_WIDTH'(6554);

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic [DIST_WIDTH-1:0] dist_type;
endpackage

@@ hdl/s2s_req_if.sv @@
`timescale 1ns / 1ps
interface s2s_req_if;
   logic valid;
   logic ready;
   s2s_pkg::coord_type a_start_x;
   s2s_pkg::coord_type a_start_y;
   s2s_pkg::coord_type a_end_x;
   s2s_pkg::coord_type a_end_y;
   s2s_pkg::coord_type b_start_x;
   s2s_pkg::coord_type b_start_y;
   s2s_pkg::coord_type b_end_x;
   s2s_pkg::coord_type b_end_y;

   modport source (output valid, a_start_x, a_start_y, a_end_x, a_end_y,
                   b_start_x, b_start_y, b_end_x, b_end_y, input ready);
   modport sink (input valid, a_start_x, a_start_y, a_end_x, a_end_y,
                 b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface

@@ hdl/s2s_rsp_if.sv @@
`timescale 1ns / 1ps
interface s2s_rsp_if;
   logic valid;
   logic ready;
   s2s_pkg::dist_type distance;
   logic touching;

   modport source (output valid, distance, touching, input ready);
   modport sink (input valid, distance, touching, output ready);
endinterface

@@ hdl/segment_to_segment_distance.sv @@
`timescale 1ns / 1ps
// Distance between two 2D segments in signed Q16.8, one pair accepted per
// clock while the output buffer is not full. Every one of the four
// point-to-segment lanes runs a 16-stage restoring divider for the
// projection and a 26-stage square root, one step per stage. A two-beat output
// buffer lets input continue while a result waits; the pipeline stalls as a
// whole only while that buffer is full, so the input side never waits on the
// result side's ready in the same cycle. Register 0 (address 0) is the touch
// tolerance, register 1 (address 4) the degenerate squared length; write them
// only while no pair is in flight.
module segment_to_segment_distance (
   input  logic                                clock,
   input  logic                                reset,
   s2s_req_if.sink                             req,
   s2s_rsp_if.source                           rsp,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [s2s_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [s2s_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [s2s_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                pready
);
   localparam int DW  = s2s_pkg::DIFF_WIDTH;
   localparam int PW  = s2s_pkg::PROD_WIDTH;
   localparam int LAT = s2s_pkg::LANE_LAT;
   localparam int CW  = s2s_pkg::CFG_WIDTH;

   typedef struct packed {
      s2s_pkg::coord_type ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
   } pair_type;

   typedef struct packed {
      s2s_pkg::dist_type distance;
      logic              touching;
   } result_type;

   logic [CW-1:0] tol_ff, degen_ff;
   logic          adv;

   pair_type      pair_ff;
   logic          vld_ff [LAT+1];
   logic signed [DW-1:0] cd_ff [4][4];
   logic signed [DW-1:0] cd_in [4][4];
   logic signed [PW-1:0] cp_ff [4][2];
   logic          cdly_ff [LAT-2];
   logic          cross_in;
   s2s_pkg::dist_type d1, d2, d3, d4;
   result_type    fin_ff, fin_in;
   logic          fvld_ff;
   result_type    ent_ff [2];
   logic          wr_ff, rd_ff;
   logic [1:0]    cnt_ff;
   logic          push, pop;

   // configuration
   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff   <= s2s_pkg::TOUCH_TOL_RESET;
         degen_ff <= s2s_pkg::DEGEN_LEN_RESET;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[2])
            s2s_pkg::REG_TOUCH_TOL: tol_ff   <= pwdata[CW-1:0];
            s2s_pkg::REG_DEGEN_LEN: degen_ff <= pwdata[CW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         s2s_pkg::REG_TOUCH_TOL: prdata = s2s_pkg::CSR_DATA_WIDTH'(tol_ff);
         s2s_pkg::REG_DEGEN_LEN: prdata = s2s_pkg::CSR_DATA_WIDTH'(degen_ff);
         default:                prdata = '0;
      endcase
   end

   // advance unless the output buffer is full
   assign adv       = (cnt_ff != 2'd2);
   assign req.ready = adv;

   always_ff @(posedge clock) begin
      if (adv) begin
         pair_ff <= '{req.a_start_x, req.a_start_y, req.a_end_x, req.a_end_y,
                      req.b_start_x, req.b_start_y, req.b_end_x, req.b_end_y};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= LAT; k++) vld_ff[k] <= 1'b0;
         fvld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req.valid;
         for (int k = 1; k <= LAT; k++) vld_ff[k] <= vld_ff[k-1];
         fvld_ff <= vld_ff[LAT];
      end
   end

   // orientation tests: (cy-ay)*(bx-ax) > (by-ay)*(cx-ax)
   always_comb begin
      s2s_pkg::coord_type pax [4];
      s2s_pkg::coord_type pay [4];
      s2s_pkg::coord_type pbx [4];
      s2s_pkg::coord_type pby [4];
      s2s_pkg::coord_type pcx [4];
      s2s_pkg::coord_type pcy [4];
      pax[0] = pair_ff.ax0; pay[0] = pair_ff.ay0;
      pbx[0] = pair_ff.bx0; pby[0] = pair_ff.by0;
      pcx[0] = pair_ff.bx1; pcy[0] = pair_ff.by1;
      pax[1] = pair_ff.ax1; pay[1] = pair_ff.ay1;
      pbx[1] = pair_ff.bx0; pby[1] = pair_ff.by0;
      pcx[1] = pair_ff.bx1; pcy[1] = pair_ff.by1;
      pax[2] = pair_ff.ax0; pay[2] = pair_ff.ay0;
      pbx[2] = pair_ff.ax1; pby[2] = pair_ff.ay1;
      pcx[2] = pair_ff.bx0; pcy[2] = pair_ff.by0;
      pax[3] = pair_ff.ax0; pay[3] = pair_ff.ay0;
      pbx[3] = pair_ff.ax1; pby[3] = pair_ff.ay1;
      pcx[3] = pair_ff.bx1; pcy[3] = pair_ff.by1;
      for (int i = 0; i < 4; i++) begin
         cd_in[i][0] = DW'(pcy[i]) - DW'(pay[i]);
         cd_in[i][1] = DW'(pbx[i]) - DW'(pax[i]);
         cd_in[i][2] = DW'(pby[i]) - DW'(pay[i]);
         cd_in[i][3] = DW'(pcx[i]) - DW'(pax[i]);
      end
      cross_in = ((cp_ff[0][0] > cp_ff[0][1]) != (cp_ff[1][0] > cp_ff[1][1])) &&
                 ((cp_ff[2][0] > cp_ff[2][1]) != (cp_ff[3][0] > cp_ff[3][1]));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cd_ff <= cd_in;
         for (int i = 0; i < 4; i++) begin
            cp_ff[i][0] <= cd_ff[i][0] * cd_ff[i][1];
            cp_ff[i][1] <= cd_ff[i][2] * cd_ff[i][3];
         end
         cdly_ff[0] <= cross_in;
         for (int k = 1; k < LAT - 2; k++) cdly_ff[k] <= cdly_ff[k-1];
      end
   end

   s2s_seg_dist u_lane_b0 (
      .clock(clock), .en(adv), .degen_len_sq(degen_ff),
      .px(pair_ff.bx0), .py(pair_ff.by0),
      .x0(pair_ff.ax0), .y0(pair_ff.ay0), .x1(pair_ff.ax1), .y1(pair_ff.ay1),
      .lane_dist(d1)
   );

   s2s_seg_dist u_lane_b1 (
      .clock(clock), .en(adv), .degen_len_sq(degen_ff),
      .px(pair_ff.bx1), .py(pair_ff.by1),
      .x0(pair_ff.ax0), .y0(pair_ff.ay0), .x1(pair_ff.ax1), .y1(pair_ff.ay1),
      .lane_dist(d2)
   );

   s2s_seg_dist u_lane_a0 (
      .clock(clock), .en(adv), .degen_len_sq(degen_ff),
      .px(pair_ff.ax0), .py(pair_ff.ay0),
      .x0(pair_ff.bx0), .y0(pair_ff.by0), .x1(pair_ff.bx1), .y1(pair_ff.by1),
      .lane_dist(d3)
   );

   s2s_seg_dist u_lane_a1 (
      .clock(clock), .en(adv), .degen_len_sq(degen_ff),
      .px(pair_ff.ax1), .py(pair_ff.ay1),
      .x0(pair_ff.bx0), .y0(pair_ff.by0), .x1(pair_ff.bx1), .y1(pair_ff.by1),
      .lane_dist(d4)
   );

   always_comb begin
      s2s_pkg::dist_type m01, m23;
      logic touch;
      m01 = (d2 < d1) ? d2 : d1;
      m23 = (d4 < d3) ? d4 : d3;
      touch = (d1 < s2s_pkg::DIST_WIDTH'(tol_ff)) ||
              (d2 < s2s_pkg::DIST_WIDTH'(tol_ff)) || cdly_ff[LAT-3];
      fin_in.touching = touch;
      fin_in.distance = touch ? '0 : ((m23 < m01) ? m23 : m01);
   end

   always_ff @(posedge clock) begin
      if (adv) fin_ff <= fin_in;
   end

   // two-beat output buffer
   assign push = adv && fvld_ff;
   assign pop  = rsp.valid && rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop)  rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) ent_ff[wr_ff] <= fin_ff;
   end

   assign rsp.valid    = (cnt_ff != 2'd0);
   assign rsp.distance = ent_ff[rd_ff].distance;
   assign rsp.touching = ent_ff[rd_ff].touching;
endmodule

@@ hdl/s2s_seg_dist.sv @@
`timescale 1ns / 1ps
module s2s_seg_dist (
   input  logic                                   clock,
   input  logic                                   en,
   input  logic [s2s_pkg::CFG_WIDTH-1:0]          degen_len_sq,
   input  s2s_pkg::coord_type                     px,
   input  s2s_pkg::coord_type                     py,
   input  s2s_pkg::coord_type                     x0,
   input  s2s_pkg::coord_type                     y0,
   input  s2s_pkg::coord_type                     x1,
   input  s2s_pkg::coord_type                     y1,
   output s2s_pkg::dist_type                      lane_dist
);
   localparam int DW = s2s_pkg::DIFF_WIDTH;
   localparam int PW = s2s_pkg::PROD_WIDTH;
   localparam int TB = s2s_pkg::T_BITS;
   localparam int EW = s2s_pkg::ERR_WIDTH;
   localparam int SW = s2s_pkg::SQ_WIDTH;
   localparam int MW = s2s_pkg::TMUL_WIDTH;

   typedef struct packed {
      logic signed [DW-1:0] dx;
      logic signed [DW-1:0] dy;
      logic signed [DW-1:0] wx;
      logic signed [DW-1:0] wy;
   } vec_type;

   typedef struct packed {
      logic signed [PW-1:0] dxx;
      logic signed [PW-1:0] dyy;
      logic signed [PW-1:0] wdx;
      logic signed [PW-1:0] wdy;
      vec_type              v;
   } prod_type;

   typedef struct packed {
      logic [PW-1:0]                          l2;
      logic signed [s2s_pkg::DOT_WIDTH-1:0]   dot;
      vec_type                                v;
   } sum_type;

   typedef struct packed {
      logic [PW-1:0] l2;
      logic [PW-1:0] rem;
      logic [TB-1:0] q;
      logic          f0;
      logic          f1;
      vec_type       v;
   } div_type;

   typedef struct packed {
      logic signed [MW-1:0] mx;
      logic signed [MW-1:0] my;
      logic signed [DW-1:0] wx;
      logic signed [DW-1:0] wy;
   } tmul_type;

   typedef struct packed {
      logic [SW-1:0] x;
      logic [SW-1:0] res;
   } root_type;

   vec_type  vec_ff,  vec_in;
   prod_type prod_ff, prod_in;
   sum_type  sum_ff,  sum_in;
   div_type  div_ff [TB+1];
   div_type  div_in [TB+1];
   tmul_type tmul_ff, tmul_in;
   logic signed [EW-1:0] ex_ff, ey_ff, ex_in, ey_in;
   logic [SW-1:0] sqx_ff, sqy_ff, sqx_in, sqy_in;
   root_type root_ff [EW+1];
   root_type root_in [EW+1];

   always_comb begin
      vec_in.dx = DW'(x1) - DW'(x0);
      vec_in.dy = DW'(y1) - DW'(y0);
      vec_in.wx = DW'(px) - DW'(x0);
      vec_in.wy = DW'(py) - DW'(y0);

      prod_in.dxx = vec_ff.dx * vec_ff.dx;
      prod_in.dyy = vec_ff.dy * vec_ff.dy;
      prod_in.wdx = vec_ff.wx * vec_ff.dx;
      prod_in.wdy = vec_ff.wy * vec_ff.dy;
      prod_in.v   = vec_ff;

      sum_in.l2  = $unsigned(prod_ff.dxx) + $unsigned(prod_ff.dyy);
      sum_in.dot = s2s_pkg::DOT_WIDTH'(prod_ff.wdx) + s2s_pkg::DOT_WIDTH'(prod_ff.wdy);
      sum_in.v   = prod_ff.v;
   end

   always_comb begin
      logic          neg;
      logic [PW:0]   shifted;
      neg = sum_ff.dot[s2s_pkg::DOT_WIDTH-1];
      div_in[0].l2  = sum_ff.l2;
      div_in[0].rem = sum_ff.dot[PW-1:0];
      div_in[0].q   = '0;
      div_in[0].f0  = (sum_ff.l2 < PW'(degen_len_sq)) || neg;
      div_in[0].f1  = !neg && (sum_ff.dot[PW-1:0] >= sum_ff.l2);
      div_in[0].v   = sum_ff.v;
      for (int k = 1; k <= TB; k++) begin
         div_in[k] = div_ff[k-1];
         shifted = {div_ff[k-1].rem, 1'b0};
         if (shifted >= {1'b0, div_ff[k-1].l2}) begin
            div_in[k].rem = PW'(shifted - {1'b0, div_ff[k-1].l2});
            div_in[k].q   = {div_ff[k-1].q[TB-2:0], 1'b1};
         end else begin
            div_in[k].rem = shifted[PW-1:0];
            div_in[k].q   = {div_ff[k-1].q[TB-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      logic [s2s_pkg::TQ_WIDTH-1:0] t;
      logic [SW-1:0]                bitv;
      logic [SW-1:0]                trial;
      if (div_ff[TB].f0) begin
         t = '0;
      end else if (div_ff[TB].f1) begin
         t = s2s_pkg::TQ_WIDTH'(1) << TB;
      end else begin
         t = {1'b0, div_ff[TB].q};
      end
      tmul_in.mx = div_ff[TB].v.dx * $signed({1'b0, t});
      tmul_in.my = div_ff[TB].v.dy * $signed({1'b0, t});
      tmul_in.wx = div_ff[TB].v.wx;
      tmul_in.wy = div_ff[TB].v.wy;

      ex_in = EW'(tmul_ff.wx) - EW'($signed(tmul_ff.mx[TB+DW-1:TB]));
      ey_in = EW'(tmul_ff.wy) - EW'($signed(tmul_ff.my[TB+DW-1:TB]));

      sqx_in = $unsigned(SW'(ex_ff) * SW'(ex_ff));
      sqy_in = $unsigned(SW'(ey_ff) * SW'(ey_ff));

      root_in[0].x   = sqx_ff + sqy_ff;
      root_in[0].res = '0;
      for (int k = 1; k <= EW; k++) begin
         bitv  = SW'(1) << (SW - 2 * k);
         trial = root_ff[k-1].res + bitv;
         if (root_ff[k-1].x >= trial) begin
            root_in[k].x   = root_ff[k-1].x - trial;
            root_in[k].res = (root_ff[k-1].res >> 1) + bitv;
         end else begin
            root_in[k].x   = root_ff[k-1].x;
            root_in[k].res = root_ff[k-1].res >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff  <= vec_in;
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
         for (int k = 0; k <= TB; k++) div_ff[k] <= div_in[k];
         tmul_ff <= tmul_in;
         ex_ff   <= ex_in;
         ey_ff   <= ey_in;
         sqx_ff  <= sqx_in;
         sqy_ff  <= sqy_in;
         for (int k = 0; k <= EW; k++) root_ff[k] <= root_in[k];
      end
   end

   assign lane_dist = root_ff[EW].res[s2s_pkg::DIST_WIDTH-1:0];
endmodule

@@ tb/sv/segment_to_segment_distance_tb.sv @@
`timescale 1ns / 1ps
module segment_to_segment_distance_tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 80;

   typedef struct {
      s2s_pkg::coord_type p[8];
   } seg_pair_type;

   typedef struct {
      s2s_pkg::dist_type distance;
      logic              touching;
   } seg_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [s2s_pkg::CSR_ADDR_WIDTH-1:0] paddr = '0;
   logic [s2s_pkg::CSR_DATA_WIDTH-1:0] pwdata = '0;
   logic [s2s_pkg::CSR_DATA_WIDTH-1:0] prdata;
   logic pready;

   s2s_req_if req_if();
   s2s_rsp_if rsp_if();

   segment_to_segment_distance dut (
      .clock(clock), .reset(reset), .req(req_if.sink), .rsp(rsp_if.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   seg_pair_type   pending_pairs[$];
   seg_result_type expected_results[$];
   seg_pair_type   cur_pair;
   logic [15:0] tol_reg = 16'd26;
   logic [15:0] degen_reg = 16'd6554;
   int          mismatches = 0;
   int          accepted = 0;
   int          cycles = 0;
   int          src_gap = 0;
   int          sink_gap = 0;
   logic        calm = 1'b0;
   logic        long_hold = 1'b0;

   function automatic longint unsigned isqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint unsigned point_dist(longint px, longint py, longint qx,
                                                  longint qy);
      longint ex, ey;
      ex = px - qx;
      ey = py - qy;
      return isqrt(longint'(ex * ex + ey * ey));
   endfunction

   function automatic longint floor_t(longint v);
      if (v >= 0) return v >>> s2s_pkg::T_BITS;
      return -(((-v) + 65535) >>> s2s_pkg::T_BITS);
   endfunction

   function automatic longint unsigned point_seg_dist(longint px, longint py, longint x0,
                                                      longint y0, longint x1, longint y1);
      longint dx, dy, l2, dot, t, rem;
      dx = x1 - x0;
      dy = y1 - y0;
      l2 = dx * dx + dy * dy;
      if (l2 < longint'(degen_reg)) return point_dist(px, py, x0, y0);
      dot = (px - x0) * dx + (py - y0) * dy;
      if (dot < 0) return point_dist(px, py, x0, y0);
      if (dot > l2) return point_dist(px, py, x1, y1);
      if (dot == l2) begin
         t = 65536;
      end else begin
         rem = dot;
         t = 0;
         for (int i = 0; i < s2s_pkg::T_BITS; i++) begin
            rem = rem << 1;
            t = t << 1;
            if (rem >= l2) begin
               rem = rem - l2;
               t = t | 1;
            end
         end
      end
      return point_dist(px, py, x0 + floor_t(dx * t), y0 + floor_t(dy * t));
   endfunction

   function automatic bit turns_left(longint ax, longint ay, longint bx, longint by,
                                     longint cx, longint cy);
      return (cy - ay) * (bx - ax) > (by - ay) * (cx - ax);
   endfunction

   function automatic seg_result_type seg_pair_distance(seg_pair_type s);
      longint c[8];
      longint unsigned d1, d2, d3, d4, m;
      bit touch;
      seg_result_type r;
      for (int i = 0; i < 8; i++) c[i] = longint'(s.p[i]);
      d1 = point_seg_dist(c[4], c[5], c[0], c[1], c[2], c[3]);
      d2 = point_seg_dist(c[6], c[7], c[0], c[1], c[2], c[3]);
      touch = (d1 < tol_reg) || (d2 < tol_reg);
      if (!touch)
         touch = (turns_left(c[0], c[1], c[4], c[5], c[6], c[7]) !=
                  turns_left(c[2], c[3], c[4], c[5], c[6], c[7])) &&
                 (turns_left(c[0], c[1], c[2], c[3], c[4], c[5]) !=
                  turns_left(c[0], c[1], c[2], c[3], c[6], c[7]));
      if (touch) begin
         r.distance = '0;
         r.touching = 1'b1;
         return r;
      end
      d3 = point_seg_dist(c[0], c[1], c[4], c[5], c[6], c[7]);
      d4 = point_seg_dist(c[2], c[3], c[4], c[5], c[6], c[7]);
      m = d1;
      if (d2 < m) m = d2;
      if (d3 < m) m = d3;
      if (d4 < m) m = d4;
      r.distance = s2s_pkg::dist_type'(m);
      r.touching = 1'b0;
      return r;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.a_start_x <= '0;
         req_if.a_start_y <= '0;
         req_if.a_end_x <= '0;
         req_if.a_end_y <= '0;
         req_if.b_start_x <= '0;
         req_if.b_start_y <= '0;
         req_if.b_end_x <= '0;
         req_if.b_end_y <= '0;
      end else if (!req_if.valid || req_if.ready) begin
         if (req_if.valid) begin
            expected_results.push_back(seg_pair_distance(cur_pair));
            accepted <= accepted + 1;
         end
         if (src_gap > 0) begin
            req_if.valid <= 1'b0;
            src_gap <= src_gap - 1;
         end else if (pending_pairs.size() == 0) begin
            req_if.valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            req_if.valid <= 1'b0;
            src_gap <= $urandom_range(0, 3);
         end else begin
            cur_pair = pending_pairs.pop_front();
            req_if.valid <= 1'b1;
            req_if.a_start_x <= cur_pair.p[0];
            req_if.a_start_y <= cur_pair.p[1];
            req_if.a_end_x <= cur_pair.p[2];
            req_if.a_end_y <= cur_pair.p[3];
            req_if.b_start_x <= cur_pair.p[4];
            req_if.b_start_y <= cur_pair.p[5];
            req_if.b_end_x <= cur_pair.p[6];
            req_if.b_end_y <= cur_pair.p[7];
         end
      end
   end

   always @(posedge clock) begin
      seg_result_type exp_r;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("unexpected beat: distance %0d touching %0b",
                           rsp_if.distance, rsp_if.touching);
            end else begin
               exp_r = expected_results.pop_front();
               if (rsp_if.distance !== exp_r.distance ||
                   rsp_if.touching !== exp_r.touching) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display("mismatch: distance exp %0d got %0d, touching exp %0b got %0b",
                              exp_r.distance, rsp_if.distance, exp_r.touching,
                              rsp_if.touching);
               end
            end
         end
         if (long_hold) begin
            rsp_if.ready <= 1'b0;
         end else if (sink_gap > 0) begin
            rsp_if.ready <= 1'b0;
            sink_gap <= sink_gap - 1;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_if.ready <= 1'b0;
            sink_gap <= $urandom_range(0, 3);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin
      wait (accepted > 150);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (300) @(posedge clock);
      long_hold <= 1'b0;
   end

   function automatic s2s_pkg::coord_type rand_coord();
      return s2s_pkg::coord_type'($urandom());
   endfunction

   function automatic seg_pair_type rand_pair();
      seg_pair_type s;
      int span, kind;
      longint base_x, base_y;
      kind = $urandom_range(0, 9);
      span = 1 << $urandom_range(3, 14);
      base_x = $signed($urandom_range(0, 2097151)) - 1048576;
      base_y = $signed($urandom_range(0, 2097151)) - 1048576;
      for (int i = 0; i < 8; i++) begin
         if (kind < 2)
            s.p[i] = rand_coord();
         else
            s.p[i] = s2s_pkg::coord_type'(((i % 2) ? base_y : base_x) +
                                          $signed($urandom_range(0, 2 * span)) - span);
      end
      unique case (kind)
         7: begin
            s.p[4] = s2s_pkg::coord_type'((s.p[0] + s.p[2]) / 2 +
                                          $signed($urandom_range(0, 60)) - 30);
            s.p[5] = s2s_pkg::coord_type'((s.p[1] + s.p[3]) / 2 +
                                          $signed($urandom_range(0, 60)) - 30);
         end
         8: begin
            s.p[2] = s2s_pkg::coord_type'(s.p[0] + $signed($urandom_range(0, 200)) - 100);
            s.p[3] = s2s_pkg::coord_type'(s.p[1] + $signed($urandom_range(0, 200)) - 100);
         end
         9: begin
            s.p[6] = s2s_pkg::coord_type'(2 * base_x - s.p[4]);
            s.p[7] = s2s_pkg::coord_type'(2 * base_y - s.p[5]);
            s.p[2] = s2s_pkg::coord_type'(2 * base_x - s.p[0]);
            s.p[3] = s2s_pkg::coord_type'(2 * base_y - s.p[1]);
         end
         default: ;
      endcase
      return s;
   endfunction

   task automatic add_pair(int c0, int c1, int c2, int c3, int c4, int c5, int c6, int c7);
      seg_pair_type s;
      s.p[0] = s2s_pkg::coord_type'(c0); s.p[1] = s2s_pkg::coord_type'(c1);
      s.p[2] = s2s_pkg::coord_type'(c2); s.p[3] = s2s_pkg::coord_type'(c3);
      s.p[4] = s2s_pkg::coord_type'(c4); s.p[5] = s2s_pkg::coord_type'(c5);
      s.p[6] = s2s_pkg::coord_type'(c6); s.p[7] = s2s_pkg::coord_type'(c7);
      pending_pairs.push_back(s);
   endtask

   task automatic add_directed();
      int mx, mn;
      mx = 8388607;
      mn = -8388608;
      add_pair(mn, mn, mx, mx, mn, mx, mx, mn);
      add_pair(mn, mn, mn, mx, mx, mn, mx, mx);
      add_pair(mx, mx, mx, mx, mn, mn, mn, mn);
      add_pair(mn, mn, mn, mn, mn, mn, mn, mn);
      add_pair(0, 0, 0, 0, 1000, 1000, 1000, 1000);
      add_pair(0, 0, 0, 0, 10, 0, 10, 0);
      add_pair(0, 0, 2560, 0, 1280, -256, 1280, 256);
      add_pair(0, 0, 2560, 0, 1280, 10, 1280, 2000);
      add_pair(0, 0, 2560, 0, 1280, 30, 1280, 2000);
      add_pair(0, 0, 2560, 0, 0, 512, 2560, 512);
      add_pair(0, 0, 2560, 0, 3000, 0, 5000, 0);
      add_pair(0, 0, 2560, 0, 2560, 0, 5000, 700);
      add_pair(0, 0, 50, 50, 300, -300, 300, 300);
      add_pair(-5000, 7, -5000, 7, 100, 100, -300, 900);
      add_pair(1, 1, 3, 2, -700, 500, 900, -400);
      add_pair(mx, 0, mn, 0, 0, mx, 0, 1);
      add_pair(-1, -1, 1, 1, -1, 1, 1, -1);
      add_pair(0, 0, 255, 255, 0, 100, 100, 0);
   endtask

   task automatic write_reg(int idx, logic [15:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= s2s_pkg::CSR_ADDR_WIDTH'(4 * idx);
      pwdata <= s2s_pkg::CSR_DATA_WIDTH'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (idx == s2s_pkg::REG_TOUCH_TOL) tol_reg = value;
      else degen_reg = value;
   endtask

   task automatic run_phase(logic [15:0] tol, logic [15:0] degen, int count, bit directed);
      write_reg(s2s_pkg::REG_TOUCH_TOL, tol);
      write_reg(s2s_pkg::REG_DEGEN_LEN, degen);
      if (directed) add_directed();
      for (int i = 0; i < count; i++) pending_pairs.push_back(rand_pair());
      wait (pending_pairs.size() == 0 && !req_if.valid && expected_results.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      run_phase(16'd26, 16'd6554, 420, 1'b1);
      run_phase(16'd0, 16'd0, 300, 1'b1);
      run_phase(16'd65535, 16'd65535, 250, 1'b1);
      run_phase(16'($urandom_range(0, 2000)), 16'($urandom()), 300, 1'b0);
      calm = 1'b1;
      run_phase(16'd100, 16'd300, 250, 1'b0);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
hdl/s2s_pkg.sv
hdl/s2s_req_if.sv
hdl/s2s_rsp_if.sv
hdl/s2s_seg_dist.sv
hdl/segment_to_segment_distance.sv
tb/sv/segment_to_segment_distance_tb.sv
